>>> hw/rtl/sas_pkg.sv
// sas_pkg: operation codes, register indexes and reset values for the
// sprite animation scaler; no dependencies
package sas_pkg;

  localparam int MODE_W  = 3;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 16;
  localparam int PIX_W   = 16;
  localparam int ADDR_W  = 14;
  localparam int COORD_W = 7;
  localparam int ANIM_W  = 2;
  localparam int FOUT_W  = 2;
  localparam int FCFG_W  = 3;
  localparam int DLY_W   = 16;

  localparam logic [MODE_W-1:0] MODE_LOAD   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TICK   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_NEXT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RENDER = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PIXEL  = 3'd4;

  localparam logic [CIDX_W-1:0] CFG_ANIM_COUNT = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_FRAMES_0   = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_FRAMES_1   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_FRAMES_2   = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_DELAY_0    = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_DELAY_1    = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_DELAY_2    = 3'd6;

  localparam logic [ANIM_W-1:0] RST_ANIM_COUNT = 2'd3;
  localparam logic [FCFG_W-1:0] RST_FRAMES     = 3'd4;
  localparam logic [DLY_W-1:0]  RST_DELAY_0    = 16'd300;
  localparam logic [DLY_W-1:0]  RST_DELAY_1    = 16'd200;
  localparam logic [DLY_W-1:0]  RST_DELAY_2    = 16'd500;
  localparam logic [DLY_W-1:0]  ELAPSED_MAX    = 16'hFFFF;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel_out;
    logic [ANIM_W-1:0] anim_now;
    logic [FOUT_W-1:0] frame_now;
    logic              dirty_flag;
  } result_t;

endpackage

>>> hw/rtl/sas_if.sv
// sas_in_if, sas_out_if: valid/ready channels for operation and result items
// depends on sas_pkg
interface sas_in_if;
  logic                         valid;
  logic                         ready;
  logic [sas_pkg::MODE_W-1:0]   mode;
  logic [sas_pkg::ADDR_W-1:0]   load_address;
  logic [sas_pkg::PIX_W-1:0]    load_pixel;
  logic [sas_pkg::COORD_W-1:0]  out_x;
  logic [sas_pkg::COORD_W-1:0]  out_y;

  modport source (output valid, mode, load_address, load_pixel, out_x, out_y,
                  input ready);
  modport sink (input valid, mode, load_address, load_pixel, out_x, out_y,
                output ready);
endinterface

interface sas_out_if;
  logic                         valid;
  logic                         ready;
  logic [sas_pkg::PIX_W-1:0]    pixel_out;
  logic [sas_pkg::ANIM_W-1:0]   anim_now;
  logic [sas_pkg::FOUT_W-1:0]   frame_now;
  logic                         dirty_flag;

  modport source (output valid, pixel_out, anim_now, frame_now, dirty_flag,
                  input ready);
  modport sink (input valid, pixel_out, anim_now, frame_now, dirty_flag,
                output ready);
endinterface

>>> hw/rtl/sprite_animation_scaler_unit.sv
// sprite_animation_scaler_unit: sprite word memory, animation/frame timing and
// nearest-neighbor pixel readout; depends on sas_pkg, sas_in_if, sas_out_if
//
// channel   dir  handshake        payload
// in_ch     in   valid/ready      mode, load_address, load_pixel, out_x, out_y
// out_ch    out  valid/ready      pixel_out, anim_now, frame_now, dirty_flag
// cfg_*     in   cfg_we only      cfg_index, cfg_data
//
// one item per cycle while out_ch is not stalled; an accepted item passes the second
// stage, then the output register, before out_ch.valid: state update and memory read
// at accept, read data lands in the second stage, then the output register. rst_n is
// synchronous; the sprite memory is not cleared. a stalled output holds the second stage, then drops in_ch.ready.
module sprite_animation_scaler_unit #(
  parameter int SPRITE_SIDE  = 32,
  parameter int SCALE_FACTOR = 4,
  parameter int MAX_FRAMES   = 4,
  parameter int ANIM_SLOTS   = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sas_in_if.sink                        in_ch,
  sas_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [sas_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [sas_pkg::CDATA_W-1:0]   cfg_data
);

  localparam int FRAME_WORDS = SPRITE_SIDE * SPRITE_SIDE;
  localparam int MEM_WORDS   = ANIM_SLOTS * MAX_FRAMES * FRAME_WORDS;
  localparam int AW          = $clog2(MEM_WORDS);
  localparam int FW          = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int RSH         = 16;
  localparam int RECIP       = ((1 << RSH) + SCALE_FACTOR - 1) / SCALE_FACTOR;
  localparam int RW          = RSH + 1;
  localparam int CW          = sas_pkg::COORD_W;

  // configuration
  logic [sas_pkg::ANIM_W-1:0] anim_count_r;
  logic [sas_pkg::FCFG_W-1:0] frames_r [3];
  logic [sas_pkg::DLY_W-1:0]  delay_r [3];

  // animation state
  logic [sas_pkg::ANIM_W-1:0] anim_r, anim_nxt;
  logic [FW-1:0]              frame_r, frame_nxt;
  logic [sas_pkg::DLY_W-1:0]  elapsed_r, elapsed_nxt;
  logic                       dirty_r, dirty_nxt;
  logic                       dirty_rep;

  // pipeline
  logic                       s1_valid_r;
  logic                       s1_rd_r;
  logic [sas_pkg::ANIM_W-1:0] s1_anim_r;
  logic [FW-1:0]              s1_frame_r;
  logic                       s1_dirty_r;
  logic                       s1_go;
  logic                       in_fire;
  logic                       out_valid_r;
  sas_pkg::result_t           out_r;

  // memory
  logic [sas_pkg::PIX_W-1:0]  mem [MEM_WORDS];
  logic [sas_pkg::PIX_W-1:0]  rdata_r;
  logic                       wr_en, rd_en;
  logic [31:0]                ld_wide;
  logic [AW:0]                rd_full;
  logic [CW+RW-1:0]           x_prod, y_prod;
  logic [CW-1:0]              sx, sy;
  logic                       pix_ok;

  // tick and next-animation helpers
  logic [sas_pkg::DLY_W-1:0]  delay_cur, elapsed_inc;
  logic [sas_pkg::FCFG_W-1:0] nfr_raw, nfr;
  logic [FW:0]                fv;
  logic [FW+3:0]              fsub;
  logic [sas_pkg::ANIM_W-1:0] nan;
  logic [sas_pkg::ANIM_W:0]   av;
  logic [FW+1:0]              frame_ext;

  assign s1_go       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    delay_cur = '0;
    nfr_raw   = sas_pkg::FCFG_W'(1);
    if (anim_r < 2'd3) begin
      delay_cur = delay_r[anim_r];
      nfr_raw   = frames_r[anim_r];
    end
    nfr = nfr_raw;
    if (nfr_raw == '0) nfr = sas_pkg::FCFG_W'(1);
    else if (32'(nfr_raw) > MAX_FRAMES) nfr = sas_pkg::FCFG_W'(MAX_FRAMES);

    // (frame + 1) mod frame count, restoring steps
    fv = (FW+1)'(frame_r) + (FW+1)'(1);
    for (int k = FW; k >= 0; k--) begin
      fsub = (FW+4)'(nfr) << k;
      if ((FW+4)'(fv) >= fsub) fv = fv - (FW+1)'(fsub);
    end

    // (anim + 1) mod anim count
    nan = anim_count_r;
    if (anim_count_r == '0) nan = sas_pkg::ANIM_W'(1);
    else if (32'(anim_count_r) > ANIM_SLOTS) nan = sas_pkg::ANIM_W'(ANIM_SLOTS);
    av = (sas_pkg::ANIM_W+1)'(anim_r) + (sas_pkg::ANIM_W+1)'(1);
    for (int k = 0; k < 3; k++) begin
      if (av >= (sas_pkg::ANIM_W+1)'(nan)) av = av - (sas_pkg::ANIM_W+1)'(nan);
    end

    elapsed_inc = (elapsed_r == sas_pkg::ELAPSED_MAX) ? elapsed_r
                                                       : elapsed_r + 16'd1;
  end

  always_comb begin
    anim_nxt    = anim_r;
    frame_nxt   = frame_r;
    elapsed_nxt = elapsed_r;
    dirty_nxt   = dirty_r;
    if (in_fire) begin
      unique case (in_ch.mode)
        sas_pkg::MODE_TICK: begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= delay_cur) begin
            frame_nxt   = FW'(fv);
            elapsed_nxt = '0;
            dirty_nxt   = 1'b1;
          end
        end
        sas_pkg::MODE_NEXT: begin
          anim_nxt    = sas_pkg::ANIM_W'(av);
          frame_nxt   = '0;
          elapsed_nxt = '0;
          dirty_nxt   = 1'b1;
        end
        default: ;
      endcase
    end
    dirty_rep = dirty_nxt;
    if (in_fire && in_ch.mode == sas_pkg::MODE_RENDER) dirty_nxt = 1'b0;
  end

  // nearest-neighbor source coordinate and word address
  assign x_prod  = (CW+RW)'(in_ch.out_x) * (CW+RW)'(RECIP);
  assign y_prod  = (CW+RW)'(in_ch.out_y) * (CW+RW)'(RECIP);
  assign sx      = x_prod[RSH +: CW];
  assign sy      = y_prod[RSH +: CW];
  assign rd_full = ((AW+1)'(anim_r) * (AW+1)'(MAX_FRAMES) + (AW+1)'(frame_r))
                   * (AW+1)'(FRAME_WORDS)
                   + (AW+1)'(sy) * (AW+1)'(SPRITE_SIDE) + (AW+1)'(sx);
  assign pix_ok  = (32'(sx) < SPRITE_SIDE) && (32'(sy) < SPRITE_SIDE)
                   && (32'(rd_full) < MEM_WORDS);
  assign ld_wide = 32'(in_ch.load_address);
  assign wr_en   = in_fire && in_ch.mode == sas_pkg::MODE_LOAD
                   && (ld_wide < MEM_WORDS);
  assign rd_en   = in_fire && in_ch.mode == sas_pkg::MODE_PIXEL && pix_ok;

  always_ff @(posedge clk) begin
    if (wr_en) mem[ld_wide[AW-1:0]] <= in_ch.load_pixel;
    if (rd_en) rdata_r <= mem[rd_full[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anim_count_r <= sas_pkg::RST_ANIM_COUNT;
      frames_r[0]  <= sas_pkg::RST_FRAMES;
      frames_r[1]  <= sas_pkg::RST_FRAMES;
      frames_r[2]  <= sas_pkg::RST_FRAMES;
      delay_r[0]   <= sas_pkg::RST_DELAY_0;
      delay_r[1]   <= sas_pkg::RST_DELAY_1;
      delay_r[2]   <= sas_pkg::RST_DELAY_2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sas_pkg::CFG_ANIM_COUNT: anim_count_r <= cfg_data[sas_pkg::ANIM_W-1:0];
        sas_pkg::CFG_FRAMES_0:   frames_r[0]  <= cfg_data[sas_pkg::FCFG_W-1:0];
        sas_pkg::CFG_FRAMES_1:   frames_r[1]  <= cfg_data[sas_pkg::FCFG_W-1:0];
        sas_pkg::CFG_FRAMES_2:   frames_r[2]  <= cfg_data[sas_pkg::FCFG_W-1:0];
        sas_pkg::CFG_DELAY_0:    delay_r[0]   <= cfg_data;
        sas_pkg::CFG_DELAY_1:    delay_r[1]   <= cfg_data;
        sas_pkg::CFG_DELAY_2:    delay_r[2]   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anim_r      <= '0;
      frame_r     <= '0;
      elapsed_r   <= '0;
      dirty_r     <= 1'b1;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      anim_r    <= anim_nxt;
      frame_r   <= frame_nxt;
      elapsed_r <= elapsed_nxt;
      dirty_r   <= dirty_nxt;
      if (in_fire) s1_valid_r <= 1'b1;
      else if (s1_go) s1_valid_r <= 1'b0;
      if (s1_go) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_rd_r    <= rd_en;
      s1_anim_r  <= anim_nxt;
      s1_frame_r <= frame_nxt;
      s1_dirty_r <= dirty_rep;
    end
  end

  assign frame_ext = (FW+2)'(s1_frame_r);

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_r.pixel_out  <= s1_rd_r ? rdata_r : '0;
      out_r.anim_now   <= s1_anim_r;
      out_r.frame_now  <= frame_ext[sas_pkg::FOUT_W-1:0];
      out_r.dirty_flag <= s1_dirty_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_out  = out_r.pixel_out;
  assign out_ch.anim_now   = out_r.anim_now;
  assign out_ch.frame_now  = out_r.frame_now;
  assign out_ch.dirty_flag = out_r.dirty_flag;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while both stages are full");

  a_read_enters_stage: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> (s1_valid_r && s1_rd_r))
    else $error("memory read without a second-stage item");

  a_render_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.mode == sas_pkg::MODE_RENDER) |=> !dirty_r)
    else $error("redraw flag not cleared by render check");

  a_anim_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(anim_r) < ANIM_SLOTS)
    else $error("current animation beyond slot count");

  a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a second-stage item");

endmodule

>>> tb/sas_pixel_frame_checker.sv
// sas_pixel_frame_checker: watches the operation, result and register ports of the
// sprite animation scaler, predicts every result item and compares it field by field
// depends on sas_pkg, sas_in_if, sas_out_if
module sas_pixel_frame_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  sas_in_if                           op_ch,
  sas_out_if                          res_ch,
  input  logic                        cfg_we,
  input  logic [sas_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [sas_pkg::CDATA_W-1:0] cfg_data,
  output int                          fail_count,
  output int                          results_checked,
  output int                          pending_results
);

  localparam int SPRITE_SIDE  = 32;
  localparam int SCALE_FACTOR = 4;
  localparam int MAX_FRAMES   = 4;
  localparam int ANIM_SLOTS   = 3;
  localparam int FRAME_WORDS  = SPRITE_SIDE * SPRITE_SIDE;
  localparam int MEM_WORDS    = ANIM_SLOTS * MAX_FRAMES * FRAME_WORDS;

  logic [sas_pkg::PIX_W-1:0]  sprite_words [MEM_WORDS];
  logic [sas_pkg::ANIM_W-1:0] live_anim;
  logic [sas_pkg::FOUT_W-1:0] live_frame;
  logic [sas_pkg::DLY_W-1:0]  elapsed;
  logic                       redraw;

  logic [sas_pkg::ANIM_W-1:0] anim_count_reg;
  logic [sas_pkg::FCFG_W-1:0] frames_reg [3];
  logic [sas_pkg::DLY_W-1:0]  delay_reg [3];

  sas_pkg::result_t pending_pixel_frames [$];

  function automatic int unsigned anims_in_use();
    int unsigned n;
    n = 32'(anim_count_reg);
    if (n == 0) n = 1;
    if (n > ANIM_SLOTS) n = ANIM_SLOTS;
    return n;
  endfunction

  function automatic int unsigned frames_of(input int unsigned a);
    int unsigned n;
    n = (a < 3) ? 32'(frames_reg[2'(a)]) : 1;
    if (n == 0) n = 1;
    if (n > MAX_FRAMES) n = MAX_FRAMES;
    return n;
  endfunction

  function automatic sas_pkg::result_t next_pixel_frame(
    input logic [sas_pkg::MODE_W-1:0]  mode,
    input logic [sas_pkg::ADDR_W-1:0]  addr,
    input logic [sas_pkg::PIX_W-1:0]   word,
    input logic [sas_pkg::COORD_W-1:0] ox,
    input logic [sas_pkg::COORD_W-1:0] oy
  );
    sas_pkg::result_t r;
    int unsigned      dly;
    int unsigned      sx;
    int unsigned      sy;
    int unsigned      wa;
    r = '0;
    case (mode)
      sas_pkg::MODE_LOAD: begin
        if (32'(addr) < MEM_WORDS) sprite_words[addr] = word;
      end
      sas_pkg::MODE_TICK: begin
        dly = (live_anim < 3) ? 32'(delay_reg[live_anim]) : 0;
        if (elapsed != sas_pkg::ELAPSED_MAX) elapsed = elapsed + 1'b1;
        if (32'(elapsed) >= dly) begin
          live_frame = sas_pkg::FOUT_W'((32'(live_frame) + 1) % frames_of(32'(live_anim)));
          elapsed = '0;
          redraw = 1'b1;
        end
      end
      sas_pkg::MODE_NEXT: begin
        live_anim = sas_pkg::ANIM_W'((32'(live_anim) + 1) % anims_in_use());
        live_frame = '0;
        elapsed = '0;
        redraw = 1'b1;
      end
      sas_pkg::MODE_PIXEL: begin
        sx = 32'(ox) / SCALE_FACTOR;
        sy = 32'(oy) / SCALE_FACTOR;
        if (sx < SPRITE_SIDE && sy < SPRITE_SIDE) begin
          wa = (32'(live_anim) * MAX_FRAMES + 32'(live_frame)) * FRAME_WORDS
               + sy * SPRITE_SIDE + sx;
          if (wa < MEM_WORDS) r.pixel_out = sprite_words[sas_pkg::ADDR_W'(wa)];
        end
      end
      default: ;
    endcase
    r.anim_now = live_anim;
    r.frame_now = live_frame;
    r.dirty_flag = redraw;
    if (mode == sas_pkg::MODE_RENDER) redraw = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    sas_pkg::result_t want;
    if (!rst_n) begin
      live_anim = '0;
      live_frame = '0;
      elapsed = '0;
      redraw = 1'b1;
      anim_count_reg = sas_pkg::RST_ANIM_COUNT;
      frames_reg[0] = sas_pkg::RST_FRAMES;
      frames_reg[1] = sas_pkg::RST_FRAMES;
      frames_reg[2] = sas_pkg::RST_FRAMES;
      delay_reg[0] = sas_pkg::RST_DELAY_0;
      delay_reg[1] = sas_pkg::RST_DELAY_1;
      delay_reg[2] = sas_pkg::RST_DELAY_2;
      pending_pixel_frames.delete();
      fail_count = 0;
      results_checked = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sas_pkg::CFG_ANIM_COUNT: anim_count_reg = cfg_data[sas_pkg::ANIM_W-1:0];
          sas_pkg::CFG_FRAMES_0:   frames_reg[0] = cfg_data[sas_pkg::FCFG_W-1:0];
          sas_pkg::CFG_FRAMES_1:   frames_reg[1] = cfg_data[sas_pkg::FCFG_W-1:0];
          sas_pkg::CFG_FRAMES_2:   frames_reg[2] = cfg_data[sas_pkg::FCFG_W-1:0];
          sas_pkg::CFG_DELAY_0:    delay_reg[0] = cfg_data[sas_pkg::DLY_W-1:0];
          sas_pkg::CFG_DELAY_1:    delay_reg[1] = cfg_data[sas_pkg::DLY_W-1:0];
          sas_pkg::CFG_DELAY_2:    delay_reg[2] = cfg_data[sas_pkg::DLY_W-1:0];
          default: ;
        endcase
      end
      if (res_ch.valid && res_ch.ready) begin
        results_checked++;
        if (pending_pixel_frames.size() == 0) begin
          report_mismatch("unexpected result item, pixel", 0, 32'(res_ch.pixel_out));
        end else begin
          want = pending_pixel_frames.pop_front();
          if (res_ch.pixel_out !== want.pixel_out)
            report_mismatch("pixel_out", 32'(want.pixel_out), 32'(res_ch.pixel_out));
          if (res_ch.anim_now !== want.anim_now)
            report_mismatch("anim_now", 32'(want.anim_now), 32'(res_ch.anim_now));
          if (res_ch.frame_now !== want.frame_now)
            report_mismatch("frame_now", 32'(want.frame_now), 32'(res_ch.frame_now));
          if (res_ch.dirty_flag !== want.dirty_flag)
            report_mismatch("dirty_flag", 32'(want.dirty_flag), 32'(res_ch.dirty_flag));
        end
      end
      if (op_ch.valid && op_ch.ready)
        pending_pixel_frames.push_back(next_pixel_frame(op_ch.mode, op_ch.load_address,
                                                        op_ch.load_pixel, op_ch.out_x,
                                                        op_ch.out_y));
    end
    pending_results <= pending_pixel_frames.size();
  end

endmodule

>>> tb/sprite_animation_scaler_unit_tb.sv
// sprite_animation_scaler_unit_tb: fills part of the sprite memory, runs directed and random
// operation items under several register settings with random stalls, gives the verdict
// depends on sas_pkg, sas_in_if, sas_out_if, sas_pixel_frame_checker and the block
module sprite_animation_scaler_unit_tb;

  localparam int MEM_WORDS      = 12288;
  localparam int SIDE           = 32;
  localparam int SLOT_WORDS     = SIDE * SIDE;
  localparam int SLOTS          = MEM_WORDS / SLOT_WORDS;
  localparam int ADDR_TOP       = 2 ** sas_pkg::ADDR_W - 1;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_OFF       = 150;
  localparam int DRAIN_MARGIN   = 4;
  localparam logic [sas_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [sas_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [sas_pkg::CIDX_W-1:0]  cfg_index;
  logic [sas_pkg::CDATA_W-1:0] cfg_data;

  int fail_count;
  int results_checked;
  int pending_results;
  int items_sent;
  int settings_used;
  int stall_cycles;
  int idle_cycles;
  int hold_cycles;
  bit tx_random;
  bit rx_random;

  sas_in_if  op_if ();
  sas_out_if res_if ();

  sprite_animation_scaler_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (op_if),
    .out_ch   (res_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  sas_pixel_frame_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .op_ch          (op_if),
    .res_ch         (res_if),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .results_checked(results_checked),
    .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (op_if.valid && op_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (rst_n && op_if.valid && !op_if.ready) stall_cycles <= stall_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("no item accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random wait per item, optional long hold-off
  initial begin : result_sink
    int w;
    res_if.ready = 1'b0;
    wait (rst_n);
    forever begin
      w = rx_random ? $urandom_range(9, 0) : 0;
      if (hold_cycles > 0) begin
        w = hold_cycles;
        hold_cycles = 0;
      end
      if (w > 0) begin
        res_if.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  task automatic send_op(input logic [sas_pkg::MODE_W-1:0] m,
                         input logic [sas_pkg::ADDR_W-1:0] a,
                         input logic [sas_pkg::PIX_W-1:0] p,
                         input logic [sas_pkg::COORD_W-1:0] x,
                         input logic [sas_pkg::COORD_W-1:0] y);
    int gap;
    gap = tx_random ? $urandom_range(9, 0) : 0;
    if (gap > 0) begin
      op_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op_if.valid <= 1'b1;
    op_if.mode <= m;
    op_if.load_address <= a;
    op_if.load_pixel <= p;
    op_if.out_x <= x;
    op_if.out_y <= y;
    do @(posedge clk); while (!op_if.ready);
    items_sent++;
  endtask

  // columns that land in the first or last eight sprite columns
  function automatic logic [sas_pkg::COORD_W-1:0] rand_x();
    int pick;
    pick = $urandom_range(63, 0);
    if (pick >= 32) pick = pick + 64;
    return sas_pkg::COORD_W'(pick);
  endfunction

  // rows that land in the top or bottom sprite row
  function automatic logic [sas_pkg::COORD_W-1:0] rand_y();
    int pick;
    pick = $urandom_range(7, 0);
    if (pick >= 4) pick = pick + 120;
    return sas_pkg::COORD_W'(pick);
  endfunction

  task automatic send_random_op();
    int                         pick;
    logic [sas_pkg::MODE_W-1:0] m;
    logic [sas_pkg::ADDR_W-1:0] a;
    pick = $urandom_range(99, 0);
    if (pick < 15) m = sas_pkg::MODE_LOAD;
    else if (pick < 50) m = sas_pkg::MODE_TICK;
    else if (pick < 58) m = sas_pkg::MODE_NEXT;
    else if (pick < 66) m = sas_pkg::MODE_RENDER;
    else if (pick < 96) m = sas_pkg::MODE_PIXEL;
    else m = sas_pkg::MODE_W'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
    if ($urandom_range(9, 0) == 0)
      a = sas_pkg::ADDR_W'($urandom_range(ADDR_TOP, MEM_WORDS));
    else
      a = sas_pkg::ADDR_W'($urandom_range(MEM_WORDS - 1, 0));
    send_op(m, a, sas_pkg::PIX_W'($urandom), rand_x(), rand_y());
  endtask

  task automatic drain();
    op_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (DRAIN_MARGIN) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [sas_pkg::CIDX_W-1:0] idx,
                           input logic [sas_pkg::CDATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [sas_pkg::CDATA_W-1:0] n_anim, f0, f1, f2, d0, d1, d2);
    drain();
    cfg_write(sas_pkg::CFG_ANIM_COUNT, n_anim);
    cfg_write(sas_pkg::CFG_FRAMES_0, f0);
    cfg_write(sas_pkg::CFG_FRAMES_1, f1);
    cfg_write(sas_pkg::CFG_FRAMES_2, f2);
    cfg_write(sas_pkg::CFG_DELAY_0, d0);
    cfg_write(sas_pkg::CFG_DELAY_1, d1);
    cfg_write(sas_pkg::CFG_DELAY_2, d2);
    settings_used++;
  endtask

  function automatic logic [sas_pkg::CDATA_W-1:0] rand_delay();
    if ($urandom_range(9, 0) == 0) return sas_pkg::CDATA_W'($urandom);
    return sas_pkg::CDATA_W'($urandom_range(12, 0));
  endfunction

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    op_if.valid = 1'b0;
    op_if.mode = sas_pkg::MODE_LOAD;
    op_if.load_address = '0;
    op_if.load_pixel = '0;
    op_if.out_x = '0;
    op_if.out_y = '0;
    items_sent = 0;
    settings_used = 1;
    stall_cycles = 0;
    idle_cycles = 0;
    hold_cycles = 0;
    tx_random = 1'b0;
    rx_random = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the first and last eight columns of the top and bottom rows of every frame;
    // every pixel read stays inside them
    for (int s = 0; s < SLOTS; s++)
      for (int r = 0; r < 2; r++)
        for (int c = 0; c < 16; c++)
          send_op(sas_pkg::MODE_LOAD,
                  sas_pkg::ADDR_W'(s * SLOT_WORDS + r * (SIDE - 1) * SIDE
                                   + ((c < 8) ? c : c + 16)),
                  sas_pkg::PIX_W'($urandom), '0, '0);

    tx_random = 1'b1;
    rx_random = 1'b1;
    send_op(sas_pkg::MODE_RENDER, '0, '0, '0, '0);
    send_op(sas_pkg::MODE_RENDER, '0, '0, '0, '0);
    send_op(sas_pkg::MODE_PIXEL, '0, '0, 7'd0, 7'd0);
    send_op(sas_pkg::MODE_PIXEL, '0, '0, 7'd127, 7'd127);
    send_op(sas_pkg::MODE_PIXEL, '0, '0, 7'd127, 7'd0);
    send_op(sas_pkg::MODE_PIXEL, '0, '0, 7'd0, 7'd127);
    send_op(sas_pkg::MODE_LOAD, 14'd0, 16'hFFFF, '0, '0);
    send_op(sas_pkg::MODE_LOAD, sas_pkg::ADDR_W'(MEM_WORDS - 1), 16'h0000, '0, '0);
    send_op(sas_pkg::MODE_LOAD, sas_pkg::ADDR_W'(MEM_WORDS), 16'h1234, '0, '0);
    send_op(sas_pkg::MODE_LOAD, sas_pkg::ADDR_W'(ADDR_TOP), 16'hABCD, 7'h7F, 7'h7F);
    send_op(sas_pkg::MODE_PIXEL, '0, '0, 7'd3, 7'd3);
    send_op(sas_pkg::MODE_PIXEL, '0, '0, 7'd4, 7'd0);
    repeat (3) send_op(sas_pkg::MODE_TICK, '0, '0, '0, '0);
    repeat (3) send_op(sas_pkg::MODE_NEXT, '0, '0, '0, '0);
    send_op(sas_pkg::MODE_PIXEL, '0, '0, 7'd2, 7'd1);
    send_op(sas_pkg::MODE_RENDER, '0, '0, '0, '0);
    send_op(MODE_SPARE_LO, 14'h3FFF, 16'hFFFF, 7'h7F, 7'h7F);
    send_op(MODE_SPARE_LO + 3'd1, '0, '0, '0, '0);
    send_op(MODE_SPARE_HI, '0, '0, '0, '0);
    send_op(sas_pkg::MODE_PIXEL, '0, '0, 7'd126, 7'd125);

    repeat (200) send_random_op();

    // long result hold-off while items keep coming
    drain();
    tx_random = 1'b0;
    hold_cycles = HOLD_OFF;
    repeat (40) send_random_op();
    tx_random = 1'b1;

    set_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    repeat (200) send_random_op();

    set_regs(16'd3, 16'd4, 16'd4, 16'd4, 16'd2, 16'd3, 16'd5);
    tx_random = 1'b0;
    repeat (200) send_random_op();
    tx_random = 1'b1;

    // zero and oversized counts, zero delays
    set_regs(16'd0, 16'd0, 16'd7, 16'd5, 16'd0, 16'd0, 16'd0);
    rx_random = 1'b0;
    repeat (150) send_random_op();
    rx_random = 1'b1;

    // animation count reduced below the current animation
    set_regs(16'd1, 16'd4, 16'd4, 16'd4, sas_pkg::RST_DELAY_0, sas_pkg::RST_DELAY_1,
             sas_pkg::RST_DELAY_2);
    send_op(sas_pkg::MODE_NEXT, '0, '0, '0, '0);
    set_regs(16'd3, 16'd4, 16'd4, 16'd4, sas_pkg::RST_DELAY_0, sas_pkg::RST_DELAY_1,
             sas_pkg::RST_DELAY_2);
    repeat (2) send_op(sas_pkg::MODE_NEXT, '0, '0, '0, '0);
    set_regs(16'd2, 16'd4, 16'd3, 16'd2, 16'd3, 16'd4, 16'd5);
    repeat (6) send_op(sas_pkg::MODE_TICK, '0, '0, '0, '0);
    send_op(sas_pkg::MODE_PIXEL, '0, '0, 7'd28, 7'd126);
    send_op(sas_pkg::MODE_NEXT, '0, '0, '0, '0);
    send_op(sas_pkg::MODE_PIXEL, '0, '0, 7'd100, 7'd2);
    repeat (150) send_random_op();

    // longest delays, then a delay cut below the time already elapsed
    set_regs(16'd3, 16'd4, 16'd4, 16'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    tx_random = 1'b0;
    repeat (40) send_op(sas_pkg::MODE_TICK, '0, '0, '0, '0);
    set_regs(16'd3, 16'd4, 16'd4, 16'd4, 16'd7, 16'd7, 16'd7);
    send_op(sas_pkg::MODE_TICK, '0, '0, '0, '0);
    send_op(sas_pkg::MODE_PIXEL, '0, '0, 7'd120, 7'd124);
    tx_random = 1'b1;
    repeat (150) send_random_op();

    repeat (3) begin
      set_regs(sas_pkg::CDATA_W'(($urandom & 32'hFFFC) | $urandom_range(3, 0)),
               sas_pkg::CDATA_W'(($urandom & 32'hFFF8) | $urandom_range(7, 0)),
               sas_pkg::CDATA_W'(($urandom & 32'hFFF8) | $urandom_range(7, 0)),
               sas_pkg::CDATA_W'(($urandom & 32'hFFF8) | $urandom_range(7, 0)),
               rand_delay(), rand_delay(), rand_delay());
      tx_random = 1'($urandom_range(1, 0));
      rx_random = 1'($urandom_range(1, 0));
      repeat (70) send_random_op();
    end

    drain();
    $display("run covered %0d operation items over %0d register settings", items_sent,
             settings_used);
    $display("%0d result items compared, input stalled for %0d cycles", results_checked,
             stall_cycles);
    if (fail_count == 0 && pending_results == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
